[sv/fbi_pkg.sv]
// ----------------------------------------------------------------------------
// fbi_pkg
// Shared widths, constants and pipeline types of the Fresnel boundary unit.
// ----------------------------------------------------------------------------
package fbi_pkg;

  localparam int DIR_W  = 32;
  localparam int IDX_W  = 16;
  localparam int REFL_W = 17;

  localparam logic [REFL_W-1:0] REFL_ONE = 17'h1_0000;

  // Everything one item carries down the pipeline. Fields that are only
  // live over a few stages are dropped by synthesis elsewhere.
  typedef struct packed {
    logic              tir;
    logic [31:0]       dx;
    logic [31:0]       dy;
    logic [31:0]       dz;
    logic [15:0]       ni;
    logic [15:0]       nt;
    logic [30:0]       ci;
    logic [63:0]       rad;
    logic [29:0]       num_lo;
    logic [15:0]       drem;
    logic [31:0]       dq;
    logic              qovf;
    logic [30:0]       ct;
    logic [3:0][45:0]  pr;
    logic [33:0]       uxf;
    logic [33:0]       uyf;
    logic [1:0][46:0]  ra;
    logic [1:0][46:0]  rb;
    logic [1:0]        rz;
    logic [1:0][30:0]  rrem;
    logic [1:0][30:0]  rq;
    logic [2:0][30:0]  u;
    logic [2:0][61:0]  sq;
    logic [16:0]       refl;
    logic [31:0]       nrm;
    logic [2:0][31:0]  frem;
    logic [2:0][30:0]  fq;
  } fbi_side_t;

  typedef struct packed {
    logic [REFL_W-1:0] reflectance;
    logic              total_reflection;
    logic [DIR_W-1:0]  out_x;
    logic [DIR_W-1:0]  out_y;
    logic [DIR_W-1:0]  out_z;
  } fbi_res_t;

endpackage

[sv/fbi_if.sv]
// ----------------------------------------------------------------------------
// fbi_if
// Valid/ready channels of the Fresnel boundary unit: photon request in,
// reflectance and refracted direction out.
// ----------------------------------------------------------------------------
interface fbi_in_if import fbi_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;
  logic [IDX_W-1:0]        index_incident;
  logic [IDX_W-1:0]        index_transmit;

  modport source (output valid, dir_x, dir_y, dir_z, index_incident, index_transmit,
                  input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, index_incident, index_transmit,
                output ready);
endinterface

interface fbi_out_if import fbi_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic [REFL_W-1:0]       reflectance;
  logic                    total_reflection;
  logic signed [DIR_W-1:0] out_x;
  logic signed [DIR_W-1:0] out_y;
  logic signed [DIR_W-1:0] out_z;

  modport source (output valid, reflectance, total_reflection, out_x, out_y, out_z,
                  input ready);
  modport sink (input valid, reflectance, total_reflection, out_x, out_y, out_z,
                output ready);
endinterface

[sv/fresnel_boundary_interaction_unit.sv]
// ----------------------------------------------------------------------------
// fresnel_boundary_interaction_unit
// Unpolarized Fresnel reflectance and Snell refraction of a photon direction.
// ----------------------------------------------------------------------------
// One request per clock while the output skid buffer is empty. An accepted
// request passes through the pipeline's 163 register stages to the output channel.
// The longest path through it is the sin square root (31 stages), the st
// divider (30), the cos square root (31, beside the 32-stage scale divider),
// the norm square root (32, beside the 31-stage ratio dividers) and the
// renormalizing divider (31), one result bit per stage, plus a few single
// capture, product and formatting stages. A one-entry skid buffer sits on the
// output; the pipeline stalls as a whole only while that buffer is occupied.
// Total internal reflection returns reflectance one, the flag set and the
// input direction.
module fresnel_boundary_interaction_unit
  import fbi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  fbi_in_if.sink       in_chan,
  fbi_out_if.source    out_chan
);

  localparam int S_RAD1   = 1;
  localparam int S_NUM    = 33;
  localparam int S_ST0    = 34;
  localparam int S_ST_END = 63;
  localparam int S_RAD2   = 64;
  localparam int S_Q0     = 64;
  localparam int S_Q_END  = 95;
  localparam int S_MUL    = 96;
  localparam int S_DIFF   = 97;
  localparam int S_NORM   = 98;
  localparam int S_SUM    = 99;
  localparam int S_R0     = 99;
  localparam int S_R_END  = 129;
  localparam int S_SQ     = 130;
  localparam int S_REFL   = 131;
  localparam int S_F0     = 132;
  localparam int LAST     = 162;

  fbi_side_t   side_r [0:LAST];
  logic        vld_r  [0:LAST];
  fbi_side_t   s0;
  logic [31:0] dz_mag;
  logic        en;

  logic [30:0] root1;
  logic [30:0] root2;
  logic [31:0] root3;

  fbi_res_t    res;
  fbi_res_t    skid_r;
  logic        skid_full_r;
  logic        skid_full_nxt;

  function automatic logic [31:0] to_field(input logic neg, input logic [30:0] m);
    logic [31:0] v;
    v = {1'b0, m};
    return neg ? (~v + 32'd1) : v;
  endfunction

  assign en            = !skid_full_r;
  assign in_chan.ready = en;

  // ---- stage 0: capture, clamp |dz| ----
  always_comb begin
    s0     = '0;
    s0.dx  = in_chan.dir_x;
    s0.dy  = in_chan.dir_y;
    s0.dz  = in_chan.dir_z;
    s0.ni  = in_chan.index_incident;
    s0.nt  = in_chan.index_transmit;
    s0.tir = (in_chan.index_transmit == '0);
    dz_mag = in_chan.dir_z[31] ? (~in_chan.dir_z + 32'd1) : in_chan.dir_z;
    s0.ci  = (dz_mag > 32'h4000_0000) ? 31'h4000_0000 : dz_mag[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= s0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_chan.valid;
    end
  end

  // ---- square roots ----
  fbi_isqrt #(.W(62)) u_sqrt_sin (
    .clk    (clk),
    .en     (en),
    .rad_i  ({1'b0, side_r[S_RAD1].rad[60:0]}),
    .root_o (root1)
  );

  fbi_isqrt #(.W(62)) u_sqrt_cos (
    .clk    (clk),
    .en     (en),
    .rad_i  ({1'b0, side_r[S_RAD2].rad[60:0]}),
    .root_o (root2)
  );

  fbi_isqrt #(.W(64)) u_sqrt_nrm (
    .clk    (clk),
    .en     (en),
    .rad_i  (side_r[S_SUM].rad),
    .root_o (root3)
  );

  // ---- pipeline body ----
  genvar s;
  generate
    for (s = 1; s <= LAST; s++) begin : g_stage
      fbi_side_t   nx;
      logic [61:0] sqp;
      logic [46:0] num;
      logic [16:0] w17;
      logic [15:0] rprev;
      logic        bin;
      logic        qb;
      logic [63:0] prx;
      logic [63:0] pry;
      logic [31:0] mx;
      logic [31:0] my;
      logic [31:0] qv;
      logic        shf;
      logic [4:0]  shs;
      logic [31:0] w32;
      logic [30:0] rv;
      logic [61:0] rsq;
      logic [31:0] rsum;
      logic [31:0] rrnd;
      logic [32:0] w33;

      always_comb begin
        nx    = side_r[s-1];
        sqp   = '0;
        num   = '0;
        w17   = '0;
        rprev = '0;
        bin   = 1'b0;
        qb    = 1'b0;
        prx   = '0;
        pry   = '0;
        mx    = '0;
        my    = '0;
        qv    = '0;
        shf   = 1'b0;
        shs   = '0;
        w32   = '0;
        rv    = '0;
        rsq   = '0;
        rsum  = '0;
        rrnd  = '0;
        w33   = '0;

        if (s == S_RAD1) begin
          sqp    = 62'(nx.ci) * 62'(nx.ci);
          nx.rad = {2'b00, 62'h1000_0000_0000_0000 - sqp};
        end

        // st numerator ni * sin_i, split for the long divider
        if (s == S_NUM) begin
          num       = 47'(nx.ni) * 47'(root1);
          nx.drem   = num[45:30];
          nx.num_lo = num[29:0];
        end

        // st = num / nt; quotient at or above one means TIR
        if (s >= S_ST0 && s <= S_ST_END) begin
          if (s == S_ST0) begin
            nx.tir = nx.tir | (nx.drem >= nx.nt);
          end
          w17       = {nx.drem, nx.num_lo[29]};
          nx.num_lo = nx.num_lo << 1;
          if (w17 >= {1'b0, nx.nt}) begin
            nx.drem = 16'(w17 - {1'b0, nx.nt});
            qb      = 1'b1;
          end else begin
            nx.drem = w17[15:0];
          end
          nx.dq = {nx.dq[30:0], qb};
        end

        // reads st before the scale divider reuses dq
        if (s == S_RAD2) begin
          sqp    = 62'(nx.dq[29:0]) * 62'(nx.dq[29:0]);
          nx.rad = {2'b00, 62'h1000_0000_0000_0000 - sqp};
        end

        // scale q = (ni << 30) / nt, saturating to 32 bits
        if (s >= S_Q0 && s <= S_Q_END) begin
          qb = 1'b0;
          if (s == S_Q0) begin
            nx.qovf = ({2'b00, nx.ni} >= {nx.nt, 2'b00});
            rprev   = {2'b00, nx.ni[15:2]};
            bin     = nx.ni[1];
          end else begin
            rprev = nx.drem;
            bin   = (s == S_Q0 + 1) ? nx.ni[0] : 1'b0;
          end
          w17 = {rprev, bin};
          if (w17 >= {1'b0, nx.nt}) begin
            nx.drem = 16'(w17 - {1'b0, nx.nt});
            qb      = 1'b1;
          end else begin
            nx.drem = w17[15:0];
          end
          nx.dq = {nx.dq[30:0], qb};
        end

        if (s == S_MUL) begin
          nx.ct    = root2;
          nx.pr[0] = 46'(nx.ni) * 46'(nx.ci);
          nx.pr[1] = 46'(nx.nt) * 46'(root2);
          nx.pr[2] = 46'(nx.ni) * 46'(root2);
          nx.pr[3] = 46'(nx.nt) * 46'(nx.ci);
          qv       = nx.qovf ? 32'hFFFF_FFFF : nx.dq;
          mx       = nx.dx[31] ? (~nx.dx + 32'd1) : nx.dx;
          my       = nx.dy[31] ? (~nx.dy + 32'd1) : nx.dy;
          prx      = 64'(mx) * 64'(qv);
          pry      = 64'(my) * 64'(qv);
          nx.uxf   = prx[63:30];
          nx.uyf   = pry[63:30];
        end

        if (s == S_DIFF) begin
          for (int i = 0; i < 2; i++) begin
            nx.ra[i] = (nx.pr[2*i] > nx.pr[2*i+1]) ?
                       47'(nx.pr[2*i] - nx.pr[2*i+1]) : 47'(nx.pr[2*i+1] - nx.pr[2*i]);
            nx.rb[i] = 47'(nx.pr[2*i]) + 47'(nx.pr[2*i+1]);
          end
          // horizontal part too large: scale all three down by 4
          shf     = (nx.uxf[33:31] != '0) || (nx.uyf[33:31] != '0);
          nx.u[0] = shf ? nx.uxf[32:2] : nx.uxf[30:0];
          nx.u[1] = shf ? nx.uyf[32:2] : nx.uyf[30:0];
          nx.u[2] = shf ? {2'b00, nx.ct[30:2]} : nx.ct;
        end

        if (s == S_NORM) begin
          for (int i = 0; i < 2; i++) begin
            shs = '0;
            for (int j = 16; j >= 0; j--) begin
              if ((nx.rb[i] >> j) < 47'h0_8000_0000) begin
                shs = 5'(j);
              end
            end
            nx.rz[i] = (nx.rb[i] == '0);
            nx.ra[i] = nx.ra[i] >> shs;
            nx.rb[i] = nx.rb[i] >> shs;
          end
          for (int i = 0; i < 3; i++) begin
            nx.sq[i] = 62'(nx.u[i]) * 62'(nx.u[i]);
          end
        end

        if (s == S_SUM) begin
          nx.rad = 64'(nx.sq[0]) + 64'(nx.sq[1]) + 64'(nx.sq[2]);
        end

        // ratio = (a << 30) / b, a <= b
        if (s >= S_R0 && s <= S_R_END) begin
          for (int i = 0; i < 2; i++) begin
            qb  = 1'b0;
            w32 = (s == S_R0) ? {1'b0, nx.ra[i][30:0]} : {nx.rrem[i], 1'b0};
            if (w32 >= {1'b0, nx.rb[i][30:0]}) begin
              nx.rrem[i] = 31'(w32 - {1'b0, nx.rb[i][30:0]});
              qb         = 1'b1;
            end else begin
              nx.rrem[i] = w32[30:0];
            end
            nx.rq[i] = {nx.rq[i][29:0], qb};
          end
        end

        if (s == S_SQ) begin
          for (int i = 0; i < 2; i++) begin
            rv       = nx.rz[i] ? 31'h4000_0000 : nx.rq[i];
            rsq      = 62'(rv) * 62'(rv);
            nx.rq[i] = rsq[60:30];
          end
        end

        if (s == S_REFL) begin
          rsum    = 32'(nx.rq[0]) + 32'(nx.rq[1]);
          rrnd    = {1'b0, rsum[31:1]} + 32'h0000_2000;
          nx.refl = (rrnd[31:14] > 18'h1_0000) ? REFL_ONE : rrnd[30:14];
        end

        // renormalize: (u << 30) / nrm, u <= nrm
        if (s >= S_F0 && s <= LAST) begin
          if (s == S_F0) begin
            nx.nrm = root3;
          end
          for (int i = 0; i < 3; i++) begin
            qb  = 1'b0;
            w33 = (s == S_F0) ? {2'b00, nx.u[i]} : {nx.frem[i], 1'b0};
            if (w33 >= {1'b0, nx.nrm}) begin
              nx.frem[i] = 32'(w33 - {1'b0, nx.nrm});
              qb         = 1'b1;
            end else begin
              nx.frem[i] = w33[31:0];
            end
            nx.fq[i] = {nx.fq[i][29:0], qb};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          side_r[s] <= nx;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else if (en) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  endgenerate

  // ---- result formatting ----
  always_comb begin
    if (side_r[LAST].tir) begin
      res.reflectance      = REFL_ONE;
      res.total_reflection = 1'b1;
      res.out_x            = side_r[LAST].dx;
      res.out_y            = side_r[LAST].dy;
      res.out_z            = side_r[LAST].dz;
    end else begin
      res.reflectance      = side_r[LAST].refl;
      res.total_reflection = 1'b0;
      if (side_r[LAST].nrm == '0) begin
        res.out_x = to_field(side_r[LAST].dx[31], side_r[LAST].u[0]);
        res.out_y = to_field(side_r[LAST].dy[31], side_r[LAST].u[1]);
        res.out_z = to_field(side_r[LAST].dz[31], side_r[LAST].u[2]);
      end else begin
        res.out_x = to_field(side_r[LAST].dx[31], side_r[LAST].fq[0]);
        res.out_y = to_field(side_r[LAST].dy[31], side_r[LAST].fq[1]);
        res.out_z = to_field(side_r[LAST].dz[31], side_r[LAST].fq[2]);
      end
    end
  end

  // ---- output skid ----
  always_comb begin
    if (skid_full_r) begin
      skid_full_nxt = !out_chan.ready;
    end else begin
      skid_full_nxt = vld_r[LAST] && !out_chan.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else begin
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r) begin
      skid_r <= res;
    end
  end

  assign out_chan.valid            = skid_full_r | vld_r[LAST];
  assign out_chan.reflectance      = skid_full_r ? skid_r.reflectance : res.reflectance;
  assign out_chan.total_reflection = skid_full_r ? skid_r.total_reflection :
                                                   res.total_reflection;
  assign out_chan.out_x            = skid_full_r ? skid_r.out_x : res.out_x;
  assign out_chan.out_y            = skid_full_r ? skid_r.out_y : res.out_y;
  assign out_chan.out_z            = skid_full_r ? skid_r.out_z : res.out_z;

endmodule

[sv/fbi_isqrt.sv]
// ----------------------------------------------------------------------------
// fbi_isqrt
// Pipelined integer square root, floor(sqrt(rad)), one root bit per stage.
// ----------------------------------------------------------------------------
module fbi_isqrt #(
  parameter int W = 62
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   rad_i,
  output logic [W/2-1:0] root_o
);

  localparam int N = W / 2;

  logic [W-1:0]   rad_r  [0:N-1];
  logic [N+1:0]   rem_r  [0:N-1];
  logic [N-1:0]   root_r [0:N-1];

  genvar j;
  generate
    for (j = 0; j < N; j++) begin : g_step
      logic [W-1:0] rad_in;
      logic [N+1:0] rem_in;
      logic [N-1:0] root_in;
      logic [N+3:0] work;
      logic [N+3:0] trial;

      if (j == 0) begin : g_first
        assign rad_in  = rad_i;
        assign rem_in  = '0;
        assign root_in = '0;
      end else begin : g_next
        assign rad_in  = rad_r[j-1];
        assign rem_in  = rem_r[j-1];
        assign root_in = root_r[j-1];
      end

      // bring down the next two radicand bits, try root bit = 1
      assign work  = {rem_in, rad_in[W-1 -: 2]};
      assign trial = {2'b00, root_in, 2'b01};

      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[j] <= rad_in << 2;
          if (work >= trial) begin
            rem_r[j]  <= (N+2)'(work - trial);
            root_r[j] <= {root_in[N-2:0], 1'b1};
          end else begin
            rem_r[j]  <= work[N+1:0];
            root_r[j] <= {root_in[N-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign root_o = root_r[N-1];

endmodule

[dv/fbi_checker.sv]
// ----------------------------------------------------------------------------
// fbi_checker
// Watches the photon request and result channels of the Fresnel boundary
// unit, predicts reflectance, TIR flag and refracted direction per request
// and compares them in order against the returned results.
// ----------------------------------------------------------------------------
module fbi_checker
  import fbi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  fbi_in_if.sink   in_mon,
  fbi_out_if.sink  out_mon,
  output int       fail_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  fbi_res_t expected_results[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // squared |p-q|/(p+q) in Q30
  function automatic logic [63:0] contrast_sq(input logic [63:0] p, input logic [63:0] q);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    a = (p > q) ? p - q : q - p;
    b = p + q;
    if (b == 0) return 64'd1 << 30;
    while (b >= (64'd1 << 31)) begin
      a = a >> 1;
      b = b >> 1;
    end
    r = (a << 30) / b;
    return (r * r) >> 30;
  endfunction

  function automatic logic [31:0] signed_field(input logic neg, input logic [63:0] m);
    logic [63:0] v;
    v = neg ? 64'd0 - m : m;
    return v[31:0];
  endfunction

  function automatic fbi_res_t predict_interaction(input logic [31:0] dx, input logic [31:0] dy,
                                                   input logic [31:0] dz, input logic [15:0] ni_w,
                                                   input logic [15:0] nt_w);
    fbi_res_t res;
    logic [63:0] ni, nt, ci, sin_i, st, ct, rs2, rp2, r30, refl, q, ux, uy, uz, nrm, mx, my;
    logic tir;
    ni = ni_w;
    nt = nt_w;
    ci = dz[31] ? 64'd0 - {{32{1'b1}}, dz} : {32'd0, dz};
    if (ci > (64'd1 << 30)) ci = 64'd1 << 30;
    tir = (nt == 0);
    st = 0;
    if (!tir) begin
      sin_i = int_sqrt((64'd1 << 60) - ci * ci);
      st = (ni * sin_i) / nt;
      if (st >= (64'd1 << 30)) tir = 1'b1;
    end
    if (tir) begin
      res.reflectance = REFL_ONE;
      res.total_reflection = 1'b1;
      res.out_x = dx;
      res.out_y = dy;
      res.out_z = dz;
      return res;
    end
    ct = int_sqrt((64'd1 << 60) - st * st);
    rs2 = contrast_sq(ni * ci, nt * ct);
    rp2 = contrast_sq(ni * ct, nt * ci);
    r30 = (rs2 + rp2) >> 1;
    refl = (r30 + (64'd1 << 13)) >> 14;
    if (refl > 64'd65536) refl = 64'd65536;
    q = (ni << 30) / nt;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    mx = dx[31] ? 64'd0 - {{32{1'b1}}, dx} : {32'd0, dx};
    my = dy[31] ? 64'd0 - {{32{1'b1}}, dy} : {32'd0, dy};
    ux = (mx * q) >> 30;
    uy = (my * q) >> 30;
    uz = ct;
    if (ux >= (64'd1 << 31) || uy >= (64'd1 << 31)) begin
      ux = ux >> 2;
      uy = uy >> 2;
      uz = uz >> 2;
    end
    nrm = int_sqrt(ux * ux + uy * uy + uz * uz);
    if (nrm != 0) begin
      ux = (ux << 30) / nrm;
      uy = (uy << 30) / nrm;
      uz = (uz << 30) / nrm;
    end
    res.reflectance = refl[16:0];
    res.total_reflection = 1'b0;
    res.out_x = signed_field(dx[31], ux);
    res.out_y = signed_field(dy[31], uy);
    res.out_z = signed_field(dz[31], uz);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = expected_results.size();

  always @(posedge clk) begin
    fbi_res_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        expected_results = {expected_results, predict_interaction(in_mon.dir_x, in_mon.dir_y,
          in_mon.dir_z, in_mon.index_incident, in_mon.index_transmit)};
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_mon.out_x, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_mon.reflectance !== want.reflectance)
            report_mismatch("reflectance", out_mon.reflectance, want.reflectance);
          if (out_mon.total_reflection !== want.total_reflection)
            report_mismatch("total_reflection", out_mon.total_reflection,
                            want.total_reflection);
          if (out_mon.out_x !== want.out_x) report_mismatch("out_x", out_mon.out_x, want.out_x);
          if (out_mon.out_y !== want.out_y) report_mismatch("out_y", out_mon.out_y, want.out_y);
          if (out_mon.out_z !== want.out_z) report_mismatch("out_z", out_mon.out_z, want.out_z);
        end
      end
    end
  end
endmodule

[dv/tb_fresnel_boundary_interaction_unit.sv]
// ----------------------------------------------------------------------------
// tb_fresnel_boundary_interaction_unit
// Drives photon requests (directed corners, then random directions and
// indices) with bursty input and a stalling receiver; the checker does the
// prediction and comparison, this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_fresnel_boundary_interaction_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY       = 163;
  localparam int N_RANDOM      = 750;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_START    = 600;
  localparam int HOLD_CYCLES   = 400;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [31:0] NEG_ONE_Q30 = 32'hC000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  logic hold_off = 1'b0;
  logic stim_done = 1'b0;

  fbi_in_if  in_chan ();
  fbi_out_if out_chan ();

  fresnel_boundary_interaction_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  fbi_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan.sink),
    .out_mon    (out_chan.sink),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.dir_x = '0;
    in_chan.dir_y = '0;
    in_chan.dir_z = '0;
    in_chan.index_incident = 16'h4000;
    in_chan.index_transmit = 16'h4000;
    out_chan.ready = 1'b0;
  end

  // receiver: own stall pattern, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_chan.ready <= 1'b0;
    else case ($urandom_range(0, 3))
      0: out_chan.ready <= ($urandom_range(0, 3) == 0);
      default: out_chan.ready <= 1'b1;
    endcase
  end

  // long hold-off, long enough to fill the pipeline and stall the sender
  initial begin
    wait (rst_n);
    repeat (HOLD_START) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (in_chan.valid && in_chan.ready || out_chan.valid && out_chan.ready) idle_cycles <= 0;
    else if (rst_n) idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(0, 7))
      0: return ONE_Q30;
      1: return NEG_ONE_Q30;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
    endcase
  endfunction

  function automatic logic [15:0] rand_index();
    case ($urandom_range(0, 5))
      0: return 16'($urandom());
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'h4000, 16'h9000));
    endcase
  endfunction

  task automatic send_request(input logic [31:0] dx, input logic [31:0] dy,
                              input logic [31:0] dz, input logic [15:0] ni,
                              input logic [15:0] nt);
    in_chan.valid <= 1'b1;
    in_chan.dir_x <= dx;
    in_chan.dir_y <= dy;
    in_chan.dir_z <= dz;
    in_chan.index_incident <= ni;
    in_chan.index_transmit <= nt;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic pause_sender();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int burst;
    logic [31:0] cx;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // corners: normal incidence, grazing, TIR, zero/max indices, odd bits
    send_request(0, 0, ONE_Q30, 16'h4000, 16'h6000);
    send_request(0, 0, NEG_ONE_Q30, 16'h6000, 16'h4000);
    send_request(0, 0, 32'h7FFF_FFFF, 16'h4000, 16'h8000);
    send_request(0, 0, 32'h8000_0000, 16'hFFFF, 16'h4000);
    send_request(ONE_Q30, 0, 0, 16'h4000, 16'h6000);
    send_request(32'h2D41_3CCD, 32'hD2BE_C333, 32'h2000_0000, 16'h6000, 16'h4000);
    send_request(32'h2D41_3CCD, 0, 32'h2D41_3CCD, 16'h6000, 16'h4000);
    send_request(32'h2D41_3CCD, 0, 32'h2D41_3CCD, 16'h4000, 16'h0000);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h1000_0000, 16'hFFFF, 16'h4000);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h3FFF_0000, 16'h4000, 16'hFFFF);
    send_request(32'hFFFF_FFFF, 32'h0000_0001, 32'h3FFF_FFFF, 16'h0000, 16'h4000);
    send_request(32'h3000_0000, 32'h1000_0000, 32'hE000_0000, 16'h0000, 16'h0000);
    send_request(32'h1000_0000, 32'h1000_0000, 32'h3800_0000, 16'hFFFF, 16'hFFFF);
    send_request(0, ONE_Q30, 0, 16'h5555, 16'hAAAA);
    send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 16'hAAAA, 16'h5555);
    send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA);
    for (int i = 0; i < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && i < N_RANDOM; k++, i++) begin
        cx = rand_dir();
        send_request(cx, rand_dir(), rand_dir(), rand_index(), rand_index());
      end
      pause_sender();
    end
    in_chan.valid <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    int drain;
    drain = 0;
    wait (stim_done);
    while (pending != 0 && drain < 50 * LATENCY) begin
      @(posedge clk);
      drain++;
    end
    repeat (LATENCY) @(posedge clk);
    if (pending == 0 && fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

[fresnel_boundary_interaction_unit.f]
sv/fbi_pkg.sv
sv/fbi_if.sv
sv/fbi_isqrt.sv
sv/fresnel_boundary_interaction_unit.sv
dv/fbi_checker.sv
dv/tb_fresnel_boundary_interaction_unit.sv
